// ===== hw/rtl/clcd_pkg.sv =====
// Shared types, codes and the init sequence table for the LCD nibble sequencer.
`timescale 1ns / 1ps

package clcd_pkg;

   // action codes on the request channel
   localparam logic [1:0] ACT_COMMAND = 2'd0;
   localparam logic [1:0] ACT_DATA    = 2'd1;
   localparam logic [1:0] ACT_GOTO    = 2'd2;
   localparam logic [1:0] ACT_INIT    = 2'd3;

   // configuration register indexes
   localparam logic [2:0] CSR_ROWS_IN_USE    = 3'd0;
   localparam logic [2:0] CSR_COLUMNS_IN_USE = 3'd1;
   localparam logic [2:0] CSR_ROW1_BASE      = 3'd2;
   localparam logic [2:0] CSR_ROW2_BASE      = 3'd3;
   localparam logic [2:0] CSR_ROW3_BASE      = 3'd4;
   localparam logic [2:0] CSR_ROW4_BASE      = 3'd5;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] INIT_LAST_STEP = 4'd14;

   localparam logic [11:0] BYTE_WAIT = 12'd10;

   typedef enum logic [1:0] {
      JOB_BYTE,
      JOB_ERROR,
      JOB_INIT
   } job_kind_type;

   // one classified job handed from front to back
   typedef struct packed {
      job_kind_type kind;
      logic         rs;
      logic [7:0]   data;
   } job_type;

   typedef struct packed {
      logic        strobe;
      logic [3:0]  nibble;
      logic [11:0] wait_units;
   } init_entry_type;

   // power-up sequence, all on the command register
   function automatic init_entry_type init_entry(input logic [STEP_W-1:0] step);
      init_entry_type e;
      e = '{strobe: 1'b1, nibble: 4'h0, wait_units: BYTE_WAIT};
      case (step)
         4'd0:    e = '{strobe: 1'b0, nibble: 4'h0, wait_units: 12'd4000};
         4'd1:    e = '{strobe: 1'b1, nibble: 4'h3, wait_units: 12'd1101};
         4'd2:    e = '{strobe: 1'b1, nibble: 4'h3, wait_units: 12'd101};
         4'd3:    e = '{strobe: 1'b1, nibble: 4'h3, wait_units: 12'd101};
         4'd4:    e = '{strobe: 1'b1, nibble: 4'h2, wait_units: 12'd21};
         4'd5:    e.nibble = 4'h2;
         4'd6:    e.nibble = 4'hC;
         4'd7:    e.nibble = 4'h0;
         4'd8:    e.nibble = 4'h8;
         4'd9:    e.nibble = 4'h0;
         4'd10:   e.nibble = 4'h6;
         4'd11:   e.nibble = 4'h0;
         // clear display needs the long wait after its second strobe
         4'd12:   e = '{strobe: 1'b1, nibble: 4'h1, wait_units: 12'd810};
         4'd13:   e.nibble = 4'h0;
         4'd14:   e.nibble = 4'hF;
         default: e = '{strobe: 1'b0, nibble: 4'h0, wait_units: 12'd0};
      endcase
      return e;
   endfunction

endpackage

// ===== hw/rtl/clcd_front.sv =====
// Front end: config registers, request classification and goto address check.
`timescale 1ns / 1ps

module clcd_front import clcd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_write_enable,
   input  logic [2:0]    csr_index,
   input  logic [6:0]    csr_write_data,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [1:0]    req_action,
   input  logic [7:0]    req_value,
   input  logic [3:0]    req_row,
   input  logic [6:0]    req_column,
   input  logic          queue_full,
   output logic          push,
   output job_type       push_job
);

   logic [2:0] rows_ff;
   logic [6:0] columns_ff;
   logic [6:0] base_ff [4];

   logic [6:0] row_base;
   logic [7:0] addr;
   logic       goto_bad;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff    <= 3'd2;
         columns_ff <= 7'd16;
         base_ff[0] <= 7'd0;
         base_ff[1] <= 7'd64;
         base_ff[2] <= 7'd20;
         base_ff[3] <= 7'd84;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ROWS_IN_USE:    rows_ff    <= csr_write_data[2:0];
            CSR_COLUMNS_IN_USE: columns_ff <= csr_write_data;
            CSR_ROW1_BASE:      base_ff[0] <= csr_write_data;
            CSR_ROW2_BASE:      base_ff[1] <= csr_write_data;
            CSR_ROW3_BASE:      base_ff[2] <= csr_write_data;
            CSR_ROW4_BASE:      base_ff[3] <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign row_base = base_ff[2'(req_row[1:0] - 2'd1)];
   // column is at least 1 whenever the address is used
   assign addr     = {1'b0, row_base} + {1'b0, req_column} - 8'd1;

   assign goto_bad = (req_row == 4'd0) || (req_row > 4'd4) ||
                     (req_row > {1'b0, rows_ff}) ||
                     (req_column == 7'd0) || (req_column > columns_ff) ||
                     addr[7];

   always_comb begin
      push_job = '{kind: JOB_BYTE, rs: 1'b0, data: req_value};
      case (req_action) inside
         ACT_COMMAND, ACT_DATA: begin
            push_job.rs = (req_action == ACT_DATA);
         end
         ACT_GOTO: begin
            push_job.kind = goto_bad ? JOB_ERROR : JOB_BYTE;
            push_job.data = {1'b1, addr[6:0]};
         end
         ACT_INIT: begin
            push_job.kind = JOB_INIT;
         end
         default: ;
      endcase
   end

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;

endmodule

// ===== hw/rtl/clcd_queue.sv =====
// Small job queue between the front end and the bus sequencer.
`timescale 1ns / 1ps

module clcd_queue import clcd_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type head,
   output logic    empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= bump(wr_ptr_ff);
         if (pop)  rd_ptr_ff <= bump(rd_ptr_ff);
         if (push && !pop)      count_ff <= count_ff + CNT_W'(1);
         else if (pop && !push) count_ff <= count_ff - CNT_W'(1);
      end
   end

   assign head  = mem_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_W'(DEPTH));

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count exceeds depth");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");
`endif

endmodule

// ===== hw/rtl/clcd_back.sv =====
// Back end: walks each job one bus event per beat into the result register.
`timescale 1ns / 1ps

module clcd_back import clcd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  job_type     head,
   input  logic        empty,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_strobe_res,
   output logic        rsp_reg_select,
   output logic [3:0]  rsp_nibble,
   output logic [11:0] rsp_wait_units,
   output logic        rsp_error,
   output logic        rsp_last
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic              valid_ff;
   logic              strobe_ff, rs_ff, error_ff, last_ff;
   logic [3:0]        nibble_ff;
   logic [11:0]       wait_ff;

   logic              load;
   logic              strobe_in, rs_in, error_in, last_in;
   logic [3:0]        nibble_in;
   logic [11:0]       wait_in;
   init_entry_type    ie;

   assign load = !empty && (!valid_ff || rsp_ready);
   assign ie   = init_entry(step_ff);

   always_comb begin
      strobe_in = 1'b0;
      rs_in     = 1'b0;
      nibble_in = 4'h0;
      wait_in   = 12'd0;
      error_in  = 1'b0;
      last_in   = 1'b0;
      case (head.kind)
         JOB_BYTE: begin
            strobe_in = 1'b1;
            rs_in     = head.rs;
            nibble_in = (step_ff == '0) ? head.data[7:4] : head.data[3:0];
            wait_in   = BYTE_WAIT;
            last_in   = (step_ff != '0);
         end
         JOB_ERROR: begin
            error_in = 1'b1;
            last_in  = 1'b1;
         end
         JOB_INIT: begin
            strobe_in = ie.strobe;
            nibble_in = ie.nibble;
            wait_in   = ie.wait_units;
            last_in   = (step_ff == INIT_LAST_STEP);
         end
         default: begin
            error_in = 1'b1;
            last_in  = 1'b1;
         end
      endcase
   end

   assign pop     = load && last_in;
   assign step_in = last_in ? '0 : step_ff + STEP_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (load) begin
            step_ff  <= step_in;
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         strobe_ff <= strobe_in;
         rs_ff     <= rs_in;
         nibble_ff <= nibble_in;
         wait_ff   <= wait_in;
         error_ff  <= error_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_strobe_res = strobe_ff;
   assign rsp_reg_select = rs_ff;
   assign rsp_nibble     = nibble_ff;
   assign rsp_wait_units = wait_ff;
   assign rsp_error      = error_ff;
   assign rsp_last       = last_ff;

`ifndef NO_ASSERTIONS
   a_error_single: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && error_ff) |-> (last_ff && !strobe_ff && !rs_ff))
      else $error("error beat not a lone wait-free result");
   a_step_held: assert property (@(posedge clock) disable iff (reset)
      (step_ff != '0) |-> !empty)
      else $error("job left the queue mid-sequence");
   a_wait_only_init: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !strobe_ff && !error_ff) |-> (wait_ff == 12'd4000))
      else $error("unexpected wait-only beat");
`endif

endmodule

// ===== hw/rtl/char_lcd_nibble_bus_sequencer.sv =====
// An accepted request is written into the queue; its first result beat is then
// registered in the output register. Throughput: one result beat per cycle while
//   rsp_ready holds; command, data, good goto give 2 beats, bad goto 1, init 15.
// A queue of QUEUE_DEPTH jobs lets requests be taken while results are stalled.
// Synchronous active-high reset clears the queue, sequencer and config to defaults.
`timescale 1ns / 1ps

module char_lcd_nibble_bus_sequencer import clcd_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [6:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_value,
   input  logic [3:0]  req_row,
   input  logic [6:0]  req_column,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_strobe_res,
   output logic        rsp_reg_select,
   output logic [3:0]  rsp_nibble,
   output logic [11:0] rsp_wait_units,
   output logic        rsp_error,
   output logic        rsp_last
);

   logic    push, pop, full, empty;
   job_type push_job, head;

   clcd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_value        (req_value),
      .req_row          (req_row),
      .req_column       (req_column),
      .queue_full       (full),
      .push             (push),
      .push_job         (push_job)
   );

   clcd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (full),
      .pop      (pop),
      .head     (head),
      .empty    (empty)
   );

   clcd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .empty          (empty),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_strobe_res (rsp_strobe_res),
      .rsp_reg_select (rsp_reg_select),
      .rsp_nibble     (rsp_nibble),
      .rsp_wait_units (rsp_wait_units),
      .rsp_error      (rsp_error),
      .rsp_last       (rsp_last)
   );

endmodule

// ===== tb/lcd_bus_check_pkg.sv =====
// Bus event type and scoreboard for the LCD nibble sequencer testbench.
`timescale 1ns / 1ps

package lcd_bus_check_pkg;
   import clcd_pkg::*;

   typedef struct packed {
      logic        strobe;
      logic        rs;
      logic [3:0]  nibble;
      logic [11:0] wait_units;
      logic        error;
      logic        last;
   } bus_event_type;

   class lcd_bus_scoreboard;
      logic [2:0] rows_limit;
      logic [6:0] columns_limit;
      logic [6:0] row_start [4];
      bus_event_type expected_events [$];
      int         failures;

      function new();
         rows_limit    = 3'd2;
         columns_limit = 7'd16;
         row_start[0]  = 7'd0;
         row_start[1]  = 7'd64;
         row_start[2]  = 7'd20;
         row_start[3]  = 7'd84;
         failures      = 0;
      endfunction

      function void apply_register(logic [2:0] index, logic [6:0] data);
         case (index)
            CSR_ROWS_IN_USE:    rows_limit = data[2:0];
            CSR_COLUMNS_IN_USE: columns_limit = data;
            CSR_ROW1_BASE:      row_start[0] = data;
            CSR_ROW2_BASE:      row_start[1] = data;
            CSR_ROW3_BASE:      row_start[2] = data;
            CSR_ROW4_BASE:      row_start[3] = data;
            default: ;
         endcase
      endfunction

      function void push_event(logic strobe, logic rs, logic [3:0] nibble,
                               logic [11:0] wait_units, logic error, logic last);
         bus_event_type e;
         e = '{strobe, rs, nibble, wait_units, error, last};
         expected_events.push_back(e);
      endfunction

      // high nibble first, first strobe always takes the byte wait
      function void push_byte(logic [7:0] data, logic rs, logic [11:0] second_wait,
                              logic last);
         push_event(1'b1, rs, data[7:4], BYTE_WAIT, 1'b0, 1'b0);
         push_event(1'b1, rs, data[3:0], second_wait, 1'b0, last);
      endfunction

      function int pending_count();
         return expected_events.size();
      endfunction

      function void note_request(logic [1:0] action, logic [7:0] value,
                                 logic [3:0] row, logic [6:0] column);
         int addr;
         case (action)
            ACT_COMMAND, ACT_DATA:
               push_byte(value, action == ACT_DATA, BYTE_WAIT, 1'b1);
            ACT_GOTO: begin
               if (row == 0 || row > 4 || row > rows_limit ||
                   column == 0 || column > columns_limit)
                  addr = 128;
               else
                  addr = row_start[row - 1] + column - 1;
               if (addr >= 128)
                  push_event(1'b0, 1'b0, 4'h0, 12'd0, 1'b1, 1'b1);
               else
                  push_byte(8'(128 + addr), 1'b0, BYTE_WAIT, 1'b1);
            end
            default: begin
               // power-up: long wait, three 0x3 nibbles, switch to 4-bit, setup bytes
               push_event(1'b0, 1'b0, 4'h0, 12'd4000, 1'b0, 1'b0);
               push_event(1'b1, 1'b0, 4'h3, 12'd1101, 1'b0, 1'b0);
               push_event(1'b1, 1'b0, 4'h3, 12'd101, 1'b0, 1'b0);
               push_event(1'b1, 1'b0, 4'h3, 12'd101, 1'b0, 1'b0);
               push_event(1'b1, 1'b0, 4'h2, 12'd21, 1'b0, 1'b0);
               push_byte(8'h2C, 1'b0, BYTE_WAIT, 1'b0);
               push_byte(8'h08, 1'b0, BYTE_WAIT, 1'b0);
               push_byte(8'h06, 1'b0, BYTE_WAIT, 1'b0);
               push_byte(8'h01, 1'b0, 12'd810, 1'b0);
               push_byte(8'h0F, 1'b0, BYTE_WAIT, 1'b1);
            end
         endcase
      endfunction

      function string describe(bus_event_type e);
         return $sformatf("strobe=%0d rs=%0d nibble=%h wait=%0d error=%0d last=%0d",
                          e.strobe, e.rs, e.nibble, e.wait_units, e.error, e.last);
      endfunction

      function void note_failure(string text);
         failures++;
         if (failures <= 10)
            $display("%0t mismatch: %s", $realtime, text);
      endfunction

      function void check_beat(bus_event_type got);
         bus_event_type want;
         if (expected_events.size() == 0) begin
            note_failure({"beat with nothing expected: ", describe(got)});
            return;
         end
         want = expected_events.pop_front();
         if (got.strobe !== want.strobe || got.rs !== want.rs ||
             got.nibble !== want.nibble || got.wait_units !== want.wait_units ||
             got.error !== want.error || got.last !== want.last)
            note_failure({"expected ", describe(want), " got ", describe(got)});
      endfunction

      function void check_leftovers();
         if (expected_events.size() != 0)
            note_failure($sformatf("%0d expected beats never arrived",
                                   expected_events.size()));
      endfunction
   endclass

endpackage

// ===== tb/tb.sv =====
// Top-level testbench for the LCD nibble bus sequencer.
`timescale 1ns / 1ps

module tb;
   import clcd_pkg::*;
   import lcd_bus_check_pkg::*;

   localparam int HOLD_CYCLES = 200;

   logic        clock;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [6:0]  csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_action = '0;
   logic [7:0]  req_value = '0;
   logic [3:0]  req_row = '0;
   logic [6:0]  req_column = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_strobe_res;
   logic        rsp_reg_select;
   logic [3:0]  rsp_nibble;
   logic [11:0] rsp_wait_units;
   logic        rsp_error;
   logic        rsp_last;

   bit hold_results = 1'b0;
   bit results_held = 1'b0;

   lcd_bus_scoreboard board;

   char_lcd_nibble_bus_sequencer dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_value        (req_value),
      .req_row          (req_row),
      .req_column       (req_column),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_strobe_res   (rsp_strobe_res),
      .rsp_reg_select   (rsp_reg_select),
      .rsp_nibble       (rsp_nibble),
      .rsp_wait_units   (rsp_wait_units),
      .rsp_error        (rsp_error),
      .rsp_last         (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready)
         board.check_beat(bus_event_type'{rsp_strobe_res, rsp_reg_select, rsp_nibble,
                                          rsp_wait_units, rsp_error, rsp_last});
   end

   // result side: ready stretches, random stalls, one long hold on request
   initial begin
      int n;
      forever begin
         if (hold_results) begin
            rsp_ready <= 1'b0;
            results_held = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            results_held = 1'b0;
         end
         rsp_ready <= 1'b1;
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
         repeat (1 + n) @(posedge clock);
         n = pick_gap();
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
      end
   end

   task automatic send_item(input logic [1:0] action, input logic [7:0] value,
                            input logic [3:0] row, input logic [6:0] column,
                            input bit allow_gap);
      int gap;
      req_valid  <= 1'b1;
      req_action <= action;
      req_value  <= value;
      req_row    <= row;
      req_column <= column;
      do @(posedge clock); while (!req_ready);
      board.note_request(action, value, row, column);
      gap = allow_gap ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_goto(input logic [3:0] row, input logic [6:0] column);
      send_item(ACT_GOTO, 8'($urandom), row, column, 1'b1);
   endtask

   task automatic wait_for_idle();
      if (req_valid)
         req_valid <= 1'b0;
      while (board.pending_count() != 0)
         @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] index, input logic [6:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      board.apply_register(index, data);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_geometry(input logic [6:0] rows, input logic [6:0] columns,
                                 input logic [6:0] b1, input logic [6:0] b2,
                                 input logic [6:0] b3, input logic [6:0] b4);
      wait_for_idle();
      write_register(CSR_ROWS_IN_USE, rows);
      write_register(CSR_COLUMNS_IN_USE, columns);
      write_register(CSR_ROW1_BASE, b1);
      write_register(CSR_ROW2_BASE, b2);
      write_register(CSR_ROW3_BASE, b3);
      write_register(CSR_ROW4_BASE, b4);
   endtask

   task automatic shuffle_geometry();
      logic [6:0] rows;
      logic [6:0] columns;
      rows    = ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'($urandom_range(1, 4));
      columns = ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'($urandom_range(1, 80));
      write_geometry(rows, columns, 7'($urandom), 7'($urandom), 7'($urandom),
                     7'($urandom));
      // indexes past the last register must be ignored
      if ($urandom_range(0, 1) == 1)
         write_register(3'(CSR_ROW4_BASE + $urandom_range(1, 2)), 7'($urandom));
   endtask

   task automatic send_random_item(input bit allow_gap);
      int pick;
      int top_row;
      logic [3:0] row;
      logic [6:0] column;
      pick   = $urandom_range(0, 99);
      row    = 4'($urandom);
      column = 7'($urandom);
      top_row = (board.rows_limit > 3'd4) ? 4 : int'(board.rows_limit);
      // most gotos land on the screen so the address path gets exercised
      if (pick >= 70 && pick < 92 && $urandom_range(0, 3) != 0 &&
          top_row != 0 && board.columns_limit != 0) begin
         row    = 4'($urandom_range(1, top_row));
         column = 7'($urandom_range(1, board.columns_limit));
      end
      if (pick < 35)
         send_item(ACT_COMMAND, 8'($urandom), row, column, allow_gap);
      else if (pick < 70)
         send_item(ACT_DATA, 8'($urandom), row, column, allow_gap);
      else if (pick < 92)
         send_item(ACT_GOTO, 8'($urandom), row, column, allow_gap);
      else
         send_item(ACT_INIT, 8'($urandom), row, column, allow_gap);
   endtask

   initial begin
      board = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset geometry: 2 rows of 16
      send_item(ACT_COMMAND, 8'h00, 4'hF, 7'h7F, 1'b1);
      send_item(ACT_DATA, 8'hFF, 4'h0, 7'h00, 1'b1);
      send_item(ACT_COMMAND, 8'hA5, 4'($urandom), 7'($urandom), 1'b1);
      send_item(ACT_DATA, 8'h5A, 4'($urandom), 7'($urandom), 1'b1);
      send_item(ACT_INIT, 8'($urandom), 4'($urandom), 7'($urandom), 1'b1);
      send_goto(4'd1, 7'd1);
      send_goto(4'd2, 7'd16);
      send_goto(4'd0, 7'd1);
      send_goto(4'd3, 7'd1);
      send_goto(4'd1, 7'd0);
      send_goto(4'd1, 7'd17);
      send_goto(4'd15, 7'd127);

      // 4 rows of 80, last row runs past the address space
      write_geometry(7'd4, 7'd80, 7'd0, 7'd64, 7'd20, 7'd84);
      send_goto(4'd4, 7'd44);
      send_goto(4'd4, 7'd45);
      send_goto(4'd3, 7'd80);
      send_goto(4'd5, 7'd1);

      // row count above 4 and widest columns, upper bits of the write dropped
      write_geometry(7'h7F, 7'd127, 7'd127, 7'd0, 7'd127, 7'd0);
      write_register(3'(CSR_ROW4_BASE + 2), 7'h55);
      send_goto(4'd1, 7'd1);
      send_goto(4'd1, 7'd2);
      send_goto(4'd2, 7'd127);
      send_goto(4'd6, 7'd1);

      // no rows, no columns: every goto fails
      write_geometry(7'h08, 7'd0, 7'd1, 7'd2, 7'd3, 7'd4);
      send_goto(4'd1, 7'd1);
      send_item(ACT_DATA, 8'h81, 4'($urandom), 7'($urandom), 1'b1);

      write_geometry(7'd1, 7'd1, 7'($urandom), 7'($urandom), 7'($urandom),
                     7'($urandom));

      for (int i = 0; i < 150; i++) begin
         if (i % 40 == 39) begin
            wait_for_idle();
            shuffle_geometry();
         end
         if (i == 60) begin
            // stall results long enough for the queue to back up into req_ready
            req_valid <= 1'b0;
            hold_results = 1'b1;
            wait (results_held);
            hold_results = 1'b0;
            for (int j = 0; j < 10; j++)
               send_random_item(1'b0);
         end
         send_random_item(1'b1);
      end

      wait_for_idle();
      repeat (20) @(posedge clock);
      board.check_leftovers();
      if (board.failures == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
